// ===== rtl/decimal_field_formatter_defines.svh =====
// ---------------------------------------------------------------------------
// decimal_field_formatter_defines.svh
// Assertion macros shared by the formatter RTL.
// ---------------------------------------------------------------------------
`ifndef DECIMAL_FIELD_FORMATTER_DEFINES_SVH
`define DECIMAL_FIELD_FORMATTER_DEFINES_SVH

// Same-cycle implication, checked on i_clk, off during reset.
`define DFF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on i_clk, off during reset.
`define DFF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/dff_pkg.sv =====
// ---------------------------------------------------------------------------
// dff_pkg
// Types and constants of the decimal field formatter.
// ---------------------------------------------------------------------------
package dff_pkg;

    localparam int MAX_WIDTH = 16;
    localparam int DIG_MAX   = 10;

    localparam int VALUE_W  = 32;
    localparam int CHAR_W   = 7;
    localparam int MINW_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 5;
    localparam int PAD_W    = $clog2(MAX_WIDTH + 1);
    localparam int NDIG_W   = $clog2(DIG_MAX + 1);
    localparam int IDX_W    = $clog2(DIG_MAX);
    localparam int RECIP_SHIFT = 35;
    localparam int QUOT_W   = 2 * VALUE_W - RECIP_SHIFT;

    localparam logic [VALUE_W-1:0] RECIP_10 = 32'hCCCC_CCCD;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'd45;
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'd32;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGN_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_PAD    = 2'd2;

    localparam logic [MINW_W-1:0] MIN_WIDTH_RST = 5'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SIGN,
        ST_PAD,
        ST_DIGIT
    } t_state;

endpackage

// ===== rtl/decimal_field_formatter.sv =====
// ---------------------------------------------------------------------------
// decimal_field_formatter
// Formats a signed 32-bit value as decimal ASCII text, padded to a minimum field width.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_value) takes one number.
//   Output channel (o_out_valid / i_out_ready) returns one ASCII character
//   per transfer, most significant first; o_last_char marks the final one.
//   Config channel (i_cfg_valid / o_cfg_ready) writes min_width (0),
//   sign_enable (1) and zero_pad (2); other indexes are dropped. Write only
//   while the block is idle.
// Timing:
//   Digit extraction runs one divide-by-ten step per digit on the shared
//   reciprocal multiplier; each step passes through a multiply state and a
//   remainder state. Characters then leave at one per cycle while the
//   output accepts them. o_in_ready is high only between numbers.
// Reset: synchronous, active low; min_width = 2, sign off, zero padding on.
// Stall: a held output keeps its character; the sequencer waits for the
//   output register to be empty or taken before producing the next one.
// ---------------------------------------------------------------------------
module decimal_field_formatter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [dff_pkg::VALUE_W-1:0] i_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [dff_pkg::CHAR_W-1:0]   o_char_code,
    output logic                         o_last_char,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [dff_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dff_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dff_pkg::*;
    `include "decimal_field_formatter_defines.svh"

    t_state               r_state, n_state;
    logic [MINW_W-1:0]    r_min_width;
    logic                 r_sign_enable;
    logic                 r_zero_pad;

    logic [VALUE_W-1:0]   r_mag, n_mag;
    logic [QUOT_W-1:0]    r_quot;
    logic                 r_neg, n_neg;
    logic [3:0]           r_digits [DIG_MAX];
    logic [NDIG_W-1:0]    r_ndig, n_ndig;
    logic [PAD_W-1:0]     r_pad_cnt, n_pad_cnt;
    logic [IDX_W-1:0]     r_dig_idx, n_dig_idx;

    logic                 r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]    r_char, n_char;
    logic                 r_last, n_last;

    logic [2*VALUE_W-1:0] w_prod;
    logic [VALUE_W-1:0]   w_rem;
    logic [NDIG_W-1:0]    w_ndig_inc;
    logic [PAD_W-1:0]     w_width_sat;
    logic [PAD_W-1:0]     w_pad_new;
    logic                 w_accept;
    logic                 w_slot;
    logic                 w_emit;
    logic [CHAR_W-1:0]    w_char;
    logic                 w_last;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_char_code = r_char;
    assign o_last_char = r_last;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_slot   = !r_out_valid || i_out_ready;

    // Shared divide-by-ten unit: reciprocal multiply, then remainder by shift-subtract.
    assign w_prod = {{VALUE_W{1'b0}}, r_mag} * {{VALUE_W{1'b0}}, RECIP_10};
    assign w_rem  = r_mag - {r_quot, 3'b000} - {2'b00, r_quot, 1'b0};
    assign w_ndig_inc = r_ndig + NDIG_W'(1);

    always_comb begin
        if ({1'b0, r_min_width} > (MINW_W + 1)'(MAX_WIDTH)) begin
            w_width_sat = PAD_W'(MAX_WIDTH);
        end else begin
            w_width_sat = PAD_W'(r_min_width);
        end
        if (w_width_sat > PAD_W'(w_ndig_inc)) begin
            w_pad_new = w_width_sat - PAD_W'(w_ndig_inc);
        end else begin
            w_pad_new = '0;
        end
    end

    // Character selection for the emit states.
    always_comb begin
        w_emit = 1'b0;
        w_char = CH_SPACE;
        w_last = 1'b0;
        unique case (r_state)
            ST_SIGN: begin
                w_emit = w_slot;
                w_char = r_neg ? CH_MINUS : CH_SPACE;
            end
            ST_PAD: begin
                w_emit = w_slot;
                w_char = r_zero_pad ? CH_ZERO : CH_SPACE;
            end
            ST_DIGIT: begin
                w_emit = w_slot;
                w_char = CH_ZERO + {3'b000, r_digits[r_dig_idx]};
                w_last = (r_dig_idx == '0);
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                priority if (r_quot != '0) n_state = ST_MUL;
                else if (r_sign_enable)    n_state = ST_SIGN;
                else if (w_pad_new != '0)  n_state = ST_PAD;
                else                       n_state = ST_DIGIT;
            end
            ST_SIGN: begin
                if (w_emit) n_state = (r_pad_cnt != '0) ? ST_PAD : ST_DIGIT;
            end
            ST_PAD: begin
                if (w_emit && r_pad_cnt == PAD_W'(1)) n_state = ST_DIGIT;
            end
            ST_DIGIT: begin
                if (w_emit && w_last) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_mag     = r_mag;
        n_neg     = r_neg;
        n_ndig    = r_ndig;
        n_pad_cnt = r_pad_cnt;
        n_dig_idx = r_dig_idx;
        if (r_state == ST_IDLE && w_accept) begin
            n_neg  = i_value[VALUE_W-1];
            n_mag  = i_value[VALUE_W-1] ? (~i_value + VALUE_W'(1)) : i_value;
            n_ndig = '0;
        end
        if (r_state == ST_DIV) begin
            n_mag     = {3'b000, r_quot};
            n_ndig    = w_ndig_inc;
            n_pad_cnt = w_pad_new;
            n_dig_idx = r_ndig[IDX_W-1:0];
        end
        if (w_emit && r_state == ST_PAD) begin
            n_pad_cnt = r_pad_cnt - PAD_W'(1);
        end
        if (w_emit && r_state == ST_DIGIT && !w_last) begin
            n_dig_idx = r_dig_idx - IDX_W'(1);
        end
    end

    // Output register: load on emit, drain on transfer.
    always_comb begin
        n_char = r_char;
        n_last = r_last;
        if (w_emit) begin
            n_out_valid = 1'b1;
            n_char      = w_char;
            n_last      = w_last;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_out_valid   <= 1'b0;
            r_min_width   <= MIN_WIDTH_RST;
            r_sign_enable <= 1'b0;
            r_zero_pad    <= 1'b1;
            r_ndig        <= '0;
            r_pad_cnt     <= '0;
            r_dig_idx     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_ndig      <= n_ndig;
            r_pad_cnt   <= n_pad_cnt;
            r_dig_idx   <= n_dig_idx;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_MIN_WIDTH:   r_min_width   <= i_cfg_data[MINW_W-1:0];
                    CFG_SIGN_ENABLE: r_sign_enable <= i_cfg_data[0];
                    CFG_ZERO_PAD:    r_zero_pad    <= i_cfg_data[0];
                    default: begin
                        // drop writes to unknown indexes
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
        if (r_state == ST_MUL) begin
            r_quot <= w_prod[2*VALUE_W-1:RECIP_SHIFT];
        end
        if (r_state == ST_DIV) begin
            r_digits[r_ndig[IDX_W-1:0]] <= w_rem[3:0];
        end
    end

    `DFF_ASSERT_NOW(a_rem_in_range, r_state == ST_DIV, w_rem < VALUE_W'(10),
        "divide-by-ten remainder out of range")
    `DFF_ASSERT_NOW(a_digit_index, r_state == ST_DIGIT,
        NDIG_W'(r_dig_idx) < r_ndig, "digit index beyond extracted digits")
    `DFF_ASSERT_NEXT(a_accept_starts, w_accept, r_state == ST_MUL,
        "accepted item did not start extraction")
    `DFF_ASSERT_NEXT(a_last_ends_run, w_emit && w_last,
        r_state == ST_IDLE && o_out_valid && o_last_char,
        "final character did not end the run")

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for decimal_field_formatter
// Sends signed 32-bit numbers and checks every ASCII character that comes
// back, including its last-character flag, against fixed expected text or a
// formatting model held here. Register settings change between bursts, both
// handshakes idle at random, and one long output stall backs the block up into its input.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dff_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_CYCLES  = 300;
    localparam int PHASE_ITEMS   = 125;
    localparam int CFG_INTERVAL  = 40;
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_char;

    typedef struct {
        logic [MINW_W-1:0]         minw;
        bit                        sgn;
        bit                        pad;
        bit                        junk;
        logic signed [VALUE_W-1:0] value;
        string                     text;
    } t_dir_row;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [CHAR_W-1:0]     o_char_code;
    logic                  o_last_char;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Register copies as the block should hold them
    logic [MINW_W-1:0] fmt_min_width = MIN_WIDTH_RST;
    logic              fmt_sign      = 1'b0;
    logic              fmt_zero_pad  = 1'b1;

    t_char pending_chars [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit stall_request = 1'b0;
    int stall_left    = 0;
    int cycle_count   = 0;
    int mismatches    = 0;
    int numbers_sent  = 0;
    int chars_checked = 0;
    int reg_writes    = 0;

    // Expected text for the reset and boundary rows; empty text uses the model
    t_dir_row dir_rows [0:23] = '{
        '{5'd2,  1'b0, 1'b1, 1'b0, 32'sd0,           "00"},
        '{5'd2,  1'b0, 1'b1, 1'b0, 32'sd5,           "05"},
        '{5'd2,  1'b0, 1'b1, 1'b0, 32'sd2147483647,  "2147483647"},
        '{5'd2,  1'b0, 1'b1, 1'b0, 32'sh8000_0000,   "2147483648"},
        '{5'd2,  1'b0, 1'b1, 1'b0, -32'sd7,          "07"},
        '{5'd2,  1'b1, 1'b1, 1'b0, 32'sh8000_0000,   "-2147483648"},
        '{5'd2,  1'b1, 1'b1, 1'b0, 32'sd3,           " 03"},
        '{5'd2,  1'b1, 1'b1, 1'b0, -32'sd3,          "-03"},
        '{5'd0,  1'b0, 1'b1, 1'b0, 32'sd0,           "0"},
        '{5'd0,  1'b0, 1'b1, 1'b0, 32'sd42,          "42"},
        '{5'd1,  1'b1, 1'b0, 1'b0, 32'sd9,           " 9"},
        '{5'd16, 1'b0, 1'b1, 1'b0, 32'sd1,           "0000000000000001"},
        '{5'd16, 1'b0, 1'b1, 1'b0, 32'sh8000_0000,   "0000002147483648"},
        '{5'd31, 1'b1, 1'b0, 1'b0, -32'sd1,          ""},
        '{5'd31, 1'b1, 1'b0, 1'b0, 32'sd0,           ""},
        '{5'd10, 1'b1, 1'b1, 1'b0, 32'sd2147483647,  " 2147483647"},
        '{5'd10, 1'b1, 1'b1, 1'b0, -32'sd1000000000, "-1000000000"},
        '{5'd11, 1'b0, 1'b0, 1'b0, 32'sd10,          ""},
        '{5'd11, 1'b0, 1'b0, 1'b0, -32'sd99,         ""},
        '{5'd11, 1'b0, 1'b0, 1'b1, 32'sd123,         ""},
        '{5'd17, 1'b0, 1'b1, 1'b0, 32'sd4,           ""},
        '{5'd9,  1'b1, 1'b0, 1'b0, -32'sd123456789,  "-123456789"},
        '{5'd9,  1'b1, 1'b0, 1'b0, 32'sd1000000000,  " 1000000000"},
        '{5'd9,  1'b1, 1'b0, 1'b0, -32'sd2147483647, ""}
    };

    decimal_field_formatter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Output side: random idling, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (stall_request) begin
            stall_request = 1'b0;
            stall_left    = STALL_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left  = stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_char want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            chars_checked++;
            if (pending_chars.size() == 0) begin
                $error("char_code: no character expected, got %0d", o_char_code);
                mismatches++;
            end else begin
                want = pending_chars.pop_front();
                if (o_char_code !== want.code) begin
                    $error("char_code: expected %0d, got %0d", want.code, o_char_code);
                    mismatches++;
                end
                if (o_last_char !== want.last) begin
                    $error("last_char: expected %0d, got %0d", want.last, o_last_char);
                    mismatches++;
                end
            end
        end
    end

    // Append the character run the block should produce for one number
    function automatic void predict_text(input logic signed [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] mag;
        logic [3:0]         digits [0:DIG_MAX-1];
        int                 ndig;
        int                 width;
        t_char              run [$];
        mag   = v[VALUE_W-1] ? (~v + 1'b1) : v;
        ndig  = 0;
        width = (fmt_min_width > MAX_WIDTH) ? MAX_WIDTH : int'(fmt_min_width);
        do begin
            digits[ndig] = 4'(mag % 10);
            mag          = mag / 10;
            ndig++;
        end while (mag != 0 && ndig < DIG_MAX);
        if (fmt_sign)
            run.push_back('{v[VALUE_W-1] ? CH_MINUS : CH_SPACE, 1'b0});
        for (int i = ndig; i < width; i++)
            run.push_back('{fmt_zero_pad ? CH_ZERO : CH_SPACE, 1'b0});
        for (int i = ndig - 1; i >= 0; i--)
            run.push_back('{CH_ZERO + CHAR_W'(digits[i]), 1'b0});
        run[run.size() - 1].last = 1'b1;
        foreach (run[i])
            pending_chars.push_back(run[i]);
    endfunction

    function automatic void expect_text(input string text);
        byte ch;
        for (int i = 0; i < text.len(); i++) begin
            ch = text[i];
            pending_chars.push_back('{ch[CHAR_W-1:0], i == text.len() - 1});
        end
    endfunction

    // Pick a number: full range, short, near powers of ten, the extremes, or below a power of ten
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] p;
        p = 1;
        case ($urandom_range(4))
            0: v = $urandom;
            1: v = $urandom_range(999);
            2: begin
                repeat ($urandom_range(9)) p = p * 10;
                v = p - $urandom_range(1);
            end
            3: begin
                case ($urandom_range(3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'hFFFF_FFFF;
                    default: v = '0;
                endcase
            end
            default: begin
                repeat ($urandom_range(1, 9)) p = p * 10;
                v = $urandom % p;
            end
        endcase
        if ($urandom_range(1))
            v = -v;
        return v;
    endfunction

    // Drop valid, then hold until every character has come back
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        wait (pending_chars.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Leaves valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        reg_writes++;
        case (idx)
            CFG_MIN_WIDTH:   fmt_min_width = data[MINW_W-1:0];
            CFG_SIGN_ENABLE: fmt_sign      = data[0];
            CFG_ZERO_PAD:    fmt_zero_pad  = data[0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic apply_config(input logic [MINW_W-1:0] minw, input bit sgn,
                                input bit pad, input bit junk);
        wait_idle();
        write_reg(CFG_MIN_WIDTH, minw);
        // Upper data bits must be ignored for the one-bit registers
        write_reg(CFG_SIGN_ENABLE, {4'($urandom_range(15)), sgn});
        write_reg(CFG_ZERO_PAD, {4'($urandom_range(15)), pad});
        if (junk)
            write_reg(CFG_UNUSED, 5'($urandom_range(31)));
        i_cfg_valid <= 1'b0;
    endtask

    // Leaves valid high after the transfer; the next call or wait_idle lowers it
    task automatic send_number(input logic signed [VALUE_W-1:0] v, input string text);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= v;
        do @(posedge i_clk); while (!o_in_ready);
        numbers_sent++;
        if (text.len() != 0)
            expect_text(text);
        else
            predict_text(v);
        @(negedge i_clk);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input bit pressure);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % CFG_INTERVAL == 0)
                apply_config(5'($urandom_range(31)), $urandom_range(1),
                             $urandom_range(1), $urandom_range(7) == 0);
            if (pressure && n == 50)
                stall_request = 1'b1;
            if (pressure && n == 95)
                wait_idle();
            send_number(pick_value(), "");
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 20;
        recv_idle_pct = 54;
        foreach (dir_rows[r]) begin
            if (dir_rows[r].junk || dir_rows[r].minw != fmt_min_width ||
                dir_rows[r].sgn != fmt_sign || dir_rows[r].pad != fmt_zero_pad)
                apply_config(dir_rows[r].minw, dir_rows[r].sgn, dir_rows[r].pad,
                             dir_rows[r].junk);
            send_number(dir_rows[r].value, dir_rows[r].text);
        end

        run_phase(20, 54, 1'b1);
        run_phase(54, 20, 1'b0);
        run_phase(0, 0, 1'b0);

        i_in_valid <= 1'b0;
        wait (pending_chars.size() == 0);
        repeat (40) @(posedge i_clk);

        $display("Formatted %0d numbers into %0d characters across %0d register writes,",
                 numbers_sent, chars_checked, reg_writes);
        $display("with random idling on both sides and a %0d-cycle output hold-off.",
                 STALL_CYCLES);
        if (mismatches == 0 && pending_chars.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
